### hdl/cprs_pkg.sv
// cprs_pkg: shared constants, codes and types of the checker parity run splitter
// depends on nothing; used by cprs_front, cprs_queue, cprs_back and the top level by scoped names
`timescale 1ns / 1ps
`default_nettype none
package cprs_pkg;

   // packet and index sizing
   localparam int MAX_PACKET_RAYS = 64;
   localparam int RAY_IDX_W       = $clog2(MAX_PACKET_RAYS + 1);
   localparam int RAY_EXT_W       = (RAY_IDX_W > 7) ? RAY_IDX_W : 7;

   // queue between classifier and run builder
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // configuration register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_AXIS1_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_AXIS1_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_AXIS1_Z = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_AXIS2_X = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_AXIS2_Y = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_AXIS2_Z = 3'd5;

   // axis reset values, Q16.16
   localparam logic signed [31:0] AXIS_ONE  = 32'sd65536;
   localparam logic signed [31:0] AXIS_ZERO = 32'sd0;

   // classified ray word passed through the queue
   typedef struct packed {
      logic material;
      logic packet_end;
   } ray_cls_type;

   // result word
   typedef struct packed {
      logic [5:0] run_begin;
      logic [6:0] run_end;
      logic       material_select;
      logic       last_result;
   } run_word_type;

   // queue head as seen by the run builder
   typedef struct packed {
      logic        not_empty;
      ray_cls_type head;
   } queue_status_type;

endpackage
`default_nettype wire

### hdl/cprs_front.sv
// cprs_front: configuration registers and three-stage dot product classifier
// depends on cprs_pkg; pushes one material bit per ray into cprs_queue
`timescale 1ns / 1ps
`default_nettype none
module cprs_front (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_stall,
   input  wire  signed [31:0]               req_tex_u,
   input  wire  signed [31:0]               req_tex_v,
   input  wire  signed [31:0]               req_tex_w,
   input  wire                              req_packet_end,
   input  wire                              csr_valid,
   input  wire  [cprs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire  [31:0]                      csr_data,
   input  wire                              queue_full,
   output logic                             push_valid,
   output cprs_pkg::ray_cls_type            push_word
);

   logic signed [31:0] axis_ff [6];

   logic               s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic               s1_end_ff, s2_end_ff, s3_end_ff;
   logic signed [63:0] s1_prod_ff [6];
   logic signed [64:0] s2_pair1_ff, s2_pair2_ff;
   logic signed [63:0] s2_rest1_ff, s2_rest2_ff;
   logic               s3_mat_ff;

   logic               advance;
   logic signed [63:0] prod_in [6];
   logic signed [65:0] dot1_in, dot2_in;
   logic               par1_in, par2_in;

   // configuration writes, ignored beyond the last register
   always_ff @(posedge clock) begin
      if (reset) begin
         axis_ff[0] <= cprs_pkg::AXIS_ONE;
         axis_ff[1] <= cprs_pkg::AXIS_ZERO;
         axis_ff[2] <= cprs_pkg::AXIS_ZERO;
         axis_ff[3] <= cprs_pkg::AXIS_ZERO;
         axis_ff[4] <= cprs_pkg::AXIS_ONE;
         axis_ff[5] <= cprs_pkg::AXIS_ZERO;
      end else if (csr_valid) begin
         unique case (csr_index)
            cprs_pkg::CSR_AXIS1_X: axis_ff[0] <= csr_data;
            cprs_pkg::CSR_AXIS1_Y: axis_ff[1] <= csr_data;
            cprs_pkg::CSR_AXIS1_Z: axis_ff[2] <= csr_data;
            cprs_pkg::CSR_AXIS2_X: axis_ff[3] <= csr_data;
            cprs_pkg::CSR_AXIS2_Y: axis_ff[4] <= csr_data;
            cprs_pkg::CSR_AXIS2_Z: axis_ff[5] <= csr_data;
            default: ;
         endcase
      end
   end

   // whole pipe holds only when the last stage cannot push
   assign advance   = !(s3_valid_ff && queue_full);
   assign req_stall = !advance;

   // stage 1 lanes: six 32x32 products
   assign prod_in[0] = req_tex_u * axis_ff[0];
   assign prod_in[1] = req_tex_v * axis_ff[1];
   assign prod_in[2] = req_tex_w * axis_ff[2];
   assign prod_in[3] = req_tex_u * axis_ff[3];
   assign prod_in[4] = req_tex_v * axis_ff[4];
   assign prod_in[5] = req_tex_w * axis_ff[5];

   // stage 3 full dots and parity of the folded integer part
   assign dot1_in = 66'(s2_pair1_ff) + 66'(s2_rest1_ff);
   assign dot2_in = 66'(s2_pair2_ff) + 66'(s2_rest2_ff);
   assign par1_in = dot1_in[32] ^ (dot1_in[65] && (dot1_in[31:0] == 32'd0));
   assign par2_in = dot2_in[32] ^ (dot2_in[65] && (dot2_in[31:0] == 32'd0));

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   // stage payloads
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < 6; k++) begin
            s1_prod_ff[k] <= prod_in[k];
         end
         s1_end_ff   <= req_packet_end;
         s2_pair1_ff <= 65'(s1_prod_ff[0]) + 65'(s1_prod_ff[1]);
         s2_pair2_ff <= 65'(s1_prod_ff[3]) + 65'(s1_prod_ff[4]);
         s2_rest1_ff <= s1_prod_ff[2];
         s2_rest2_ff <= s1_prod_ff[5];
         s2_end_ff   <= s1_end_ff;
         s3_mat_ff   <= par1_in ^ par2_in;
         s3_end_ff   <= s2_end_ff;
      end
   end

   assign push_valid           = s3_valid_ff && !queue_full;
   assign push_word.material   = s3_mat_ff;
   assign push_word.packet_end = s3_end_ff;

endmodule
`default_nettype wire

### hdl/cprs_queue.sv
// cprs_queue: short register queue of classified rays
// depends on cprs_pkg; sits between cprs_front and cprs_back
`timescale 1ns / 1ps
`default_nettype none
module cprs_queue (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        push_valid,
   input  cprs_pkg::ray_cls_type      push_word,
   input  wire                        pop,
   output logic                       full,
   output cprs_pkg::queue_status_type status
);

   cprs_pkg::ray_cls_type          slot_ff [cprs_pkg::QUEUE_DEPTH];
   logic [cprs_pkg::QPTR_W-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [cprs_pkg::QCNT_W-1:0]    count_ff;
   logic                           do_pop;

   assign do_pop = pop && (count_ff != '0);
   assign full   = (count_ff == cprs_pkg::QCNT_W'(cprs_pkg::QUEUE_DEPTH));

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push_valid) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push_valid && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (!push_valid && do_pop) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push_valid) begin
         slot_ff[wr_ptr_ff] <= push_word;
      end
   end

   assign status.not_empty = (count_ff != '0);
   assign status.head      = slot_ff[rd_ptr_ff];

endmodule
`default_nettype wire

### hdl/cprs_back.sv
// cprs_back: run builder with output register and one pending result word
// depends on cprs_pkg; pops classified rays from cprs_queue
`timescale 1ns / 1ps
`default_nettype none
module cprs_back (
   input  wire                        clock,
   input  wire                        reset,
   input  cprs_pkg::queue_status_type status,
   output logic                       pop,
   output logic                       rsp_valid,
   input  wire                        rsp_stall,
   output cprs_pkg::run_word_type     rsp_word
);

   logic                            run_parity_ff, run_parity_in;
   logic [5:0]                      run_begin_ff, run_begin_in;
   logic [cprs_pkg::RAY_IDX_W-1:0]  ray_index_ff, ray_index_in;
   logic                            run_open_ff, run_open_in;

   logic                            out_valid_ff, out_valid_in;
   cprs_pkg::run_word_type          out_word_ff, out_word_in;
   logic                            pend_valid_ff, pend_valid_in;
   cprs_pkg::run_word_type          pend_word_ff, pend_word_in;

   logic                            out_free, ray_end, split;
   logic [cprs_pkg::RAY_EXT_W-1:0]  idx_ext, idx_next;
   cprs_pkg::run_word_type          split_word, close_word;
   logic                            mat;

   assign out_free = !out_valid_ff || !rsp_stall;
   assign pop      = status.not_empty && !pend_valid_ff && out_free;
   assign mat      = status.head.material;
   assign idx_ext  = cprs_pkg::RAY_EXT_W'(ray_index_ff);
   assign idx_next = idx_ext + 1'b1;
   assign ray_end  = status.head.packet_end ||
                     (ray_index_ff >= cprs_pkg::RAY_IDX_W'(cprs_pkg::MAX_PACKET_RAYS - 1));
   assign split    = run_open_ff && (mat != run_parity_ff);

   // run at a material change closes just before this ray
   always_comb begin
      split_word.run_begin       = run_begin_ff;
      split_word.run_end         = idx_ext[6:0];
      split_word.material_select = run_parity_ff;
      split_word.last_result     = !ray_end;
   end

   // run state and result words for the head ray
   always_comb begin
      run_parity_in = run_parity_ff;
      run_begin_in  = run_begin_ff;
      ray_index_in  = ray_index_ff;
      run_open_in   = run_open_ff;
      out_valid_in  = out_valid_ff && rsp_stall;
      out_word_in   = out_word_ff;
      pend_valid_in = pend_valid_ff;
      pend_word_in  = pend_word_ff;

      if (!run_open_ff || split) begin
         run_parity_in = mat;
         run_begin_in  = idx_ext[5:0];
      end
      run_open_in = 1'b1;

      close_word.run_begin       = run_begin_in;
      close_word.run_end         = idx_next[6:0];
      close_word.material_select = run_parity_in;
      close_word.last_result     = 1'b1;

      if (pend_valid_ff) begin
         // second result of an earlier ray goes out first
         run_parity_in = run_parity_ff;
         run_begin_in  = run_begin_ff;
         run_open_in   = run_open_ff;
         if (out_free) begin
            out_valid_in  = 1'b1;
            out_word_in   = pend_word_ff;
            pend_valid_in = 1'b0;
         end
      end else if (pop) begin
         if (ray_end) begin
            run_parity_in = 1'b0;
            run_begin_in  = '0;
            ray_index_in  = '0;
            run_open_in   = 1'b0;
         end else begin
            ray_index_in = ray_index_ff + 1'b1;
         end
         priority if (split && ray_end) begin
            out_valid_in  = 1'b1;
            out_word_in   = split_word;
            pend_valid_in = 1'b1;
            pend_word_in  = close_word;
         end else if (split) begin
            out_valid_in = 1'b1;
            out_word_in  = split_word;
         end else if (ray_end) begin
            out_valid_in = 1'b1;
            out_word_in  = close_word;
         end else begin
         end
      end else begin
         run_parity_in = run_parity_ff;
         run_begin_in  = run_begin_ff;
         run_open_in   = run_open_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         run_parity_ff <= 1'b0;
         run_begin_ff  <= '0;
         ray_index_ff  <= '0;
         run_open_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         run_parity_ff <= run_parity_in;
         run_begin_ff  <= run_begin_in;
         ray_index_ff  <= ray_index_in;
         run_open_ff   <= run_open_in;
         out_valid_ff  <= out_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      out_word_ff  <= out_word_in;
      pend_word_ff <= pend_word_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;

endmodule
`default_nettype wire

### hdl/checker_parity_run_splitter_core.sv
// from ray acceptance to rsp_: stages s1, s2 and s3, a queue slot, then the output register
// throughput: one ray per cycle if unstalled; a ray closing two runs holds the builder
// the three-stage product/sum pipe and the four-word queue lie on this path
// reset: synchronous, active high; clears pipe, queue, run state and restores default axes
// top level: depends on cprs_pkg, cprs_front, cprs_queue and cprs_back
`timescale 1ns / 1ps
`default_nettype none
module checker_parity_run_splitter_core (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_valid,
   output logic                           req_stall,
   input  wire  signed [31:0]             req_tex_u,
   input  wire  signed [31:0]             req_tex_v,
   input  wire  signed [31:0]             req_tex_w,
   input  wire                            req_packet_end,
   output logic                           rsp_valid,
   input  wire                            rsp_stall,
   output logic [5:0]                     rsp_run_begin,
   output logic [6:0]                     rsp_run_end,
   output logic                           rsp_material_select,
   output logic                           rsp_last_result,
   input  wire                            csr_valid,
   output logic                           csr_ready,
   input  wire  [cprs_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire  [31:0]                    csr_data
);

   logic                       queue_full, push_valid, pop;
   cprs_pkg::ray_cls_type      push_word;
   cprs_pkg::queue_status_type q_status;
   cprs_pkg::run_word_type     rsp_word;

   // register writes are always accepted
   assign csr_ready = 1'b1;

   // classifier
   cprs_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_tex_u      (req_tex_u),
      .req_tex_v      (req_tex_v),
      .req_tex_w      (req_tex_w),
      .req_packet_end (req_packet_end),
      .csr_valid      (csr_valid),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .queue_full     (queue_full),
      .push_valid     (push_valid),
      .push_word      (push_word)
   );

   // decoupling queue
   cprs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_word  (push_word),
      .pop        (pop),
      .full       (queue_full),
      .status     (q_status)
   );

   // run builder
   cprs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .status    (q_status),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   assign rsp_run_begin       = rsp_word.run_begin;
   assign rsp_run_end         = rsp_word.run_end;
   assign rsp_material_select = rsp_word.material_select;
   assign rsp_last_result     = rsp_word.last_result;

endmodule
`default_nettype wire

### hdl/cprs_checker.sv
// cprs_checker: port-level assertions on the result channel, bound to the top level
// depends on checker_parity_run_splitter_core
`timescale 1ns / 1ps
`default_nettype none
module cprs_checker (
   input wire                            clock,
   input wire                            reset,
   input wire                            rsp_valid,
   input wire                            rsp_stall,
   input wire [5:0]                      rsp_run_begin,
   input wire [6:0]                      rsp_run_end,
   input wire                            rsp_material_select,
   input wire                            rsp_last_result
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_run_begin) &&
         $stable(rsp_run_end) && $stable(rsp_material_select) && $stable(rsp_last_result))
      else $error("result word changed while stalled");

   // every run covers at least one ray
   a_run_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({1'b0, rsp_run_begin} < rsp_run_end))
      else $error("run end not past run begin");

   // the second word of a ray follows straight after the first
   a_second_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_result |=> rsp_valid)
      else $error("second result word missing");

   // nothing comes out straight after reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("result word right after reset");

endmodule

bind checker_parity_run_splitter_core cprs_checker u_cprs_checker (.*);
`default_nettype wire

### bench/testbench.sv
// self-checking bench for checker_parity_run_splitter_core: rays in, material runs out
// depends on cprs_pkg and checker_parity_run_splitter_core; predicts runs with its own model
`timescale 1ns / 1ps
module testbench;

   // bench sizing
   localparam int DRAIN_CYCLES = 24;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int PHASE_RAYS   = 80;
   localparam logic [cprs_pkg::CSR_IDX_W-1:0] CSR_SPARE_LO = cprs_pkg::CSR_AXIS2_Z + 3'd1;
   localparam logic [cprs_pkg::CSR_IDX_W-1:0] CSR_SPARE_HI = cprs_pkg::CSR_AXIS2_Z + 3'd2;

   // flavours of coordinate and axis values
   typedef enum int {COORD_FULL, COORD_NEAR_INT, COORD_EXTREME, COORD_ZERO} coord_kind_type;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic signed [31:0]    req_tex_u = '0;
   logic signed [31:0]    req_tex_v = '0;
   logic signed [31:0]    req_tex_w = '0;
   logic                  req_packet_end = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [5:0]            rsp_run_begin;
   logic [6:0]            rsp_run_end;
   logic                  rsp_material_select;
   logic                  rsp_last_result;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [cprs_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0]           csr_data = '0;

   // predictor state
   logic signed [31:0]    axis_cfg [6];
   logic                  run_par;
   logic [5:0]            run_start;
   logic [6:0]            ray_pos;
   logic                  run_live;
   cprs_pkg::run_word_type pending_runs [$];

   // bench bookkeeping
   logic signed [31:0]    axis_plan [6];
   logic                  calm = 1'b0;
   int                    error_count = 0;
   int                    rays_accepted = 0;
   int                    packets_closed = 0;
   int                    runs_checked = 0;
   int                    settings_applied = 0;
   int                    cycle_count = 0;

   checker_parity_run_splitter_core u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_tex_u           (req_tex_u),
      .req_tex_v           (req_tex_v),
      .req_tex_w           (req_tex_w),
      .req_packet_end      (req_packet_end),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_run_begin       (rsp_run_begin),
      .rsp_run_end         (rsp_run_end),
      .rsp_material_select (rsp_material_select),
      .rsp_last_result     (rsp_last_result),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // parity of the folded, truncated dot of one ray with one axis
   function automatic logic checker_bit(input logic signed [31:0] u, v, w, ax, ay, az);
      logic signed [67:0] tu, tv, tw, dot;
      tu = u;
      tv = v;
      tw = w;
      dot = tu * ax + tv * ay + tw * az;
      // negative exact integers gain one from the fold, fractional ones keep floor parity
      return dot[32] ^ (dot[67] && dot[31:0] == 32'd0);
   endfunction

   function automatic cprs_pkg::run_word_type make_run(input logic [5:0] b,
                                                       input logic [6:0] e,
                                                       input logic m);
      cprs_pkg::run_word_type r;
      r.run_begin       = b;
      r.run_end         = e;
      r.material_select = m;
      r.last_result     = 1'b0;
      return r;
   endfunction

   function automatic logic [31:0] random_coord(input coord_kind_type kind);
      int          whole;
      logic [15:0] frac;
      logic [31:0] r;
      case (kind)
         COORD_FULL: begin
            r = $urandom;
         end
         COORD_NEAR_INT: begin
            whole = int'($urandom_range(12)) - 6;
            case ($urandom_range(3))
               0: frac = 16'h0000;
               1: frac = 16'h0001;
               2: frac = 16'hFFFF;
               default: frac = 16'($urandom);
            endcase
            r = whole <<< 16;
            r[15:0] = frac;
         end
         COORD_EXTREME: begin
            case ($urandom_range(5))
               0: r = 32'h7FFF_FFFF;
               1: r = 32'h8000_0000;
               2: r = 32'h8000_0001;
               3: r = 32'hFFFF_FFFF;
               4: r = 32'h0001_0000;
               default: r = 32'hFFFF_0000;
            endcase
         end
         default: begin
            r = 32'd0;
         end
      endcase
      return r;
   endfunction

   // run model: tracks axis writes and predicts the runs each accepted word closes
   always @(posedge clock) begin : run_model
      logic                   mat;
      logic                   closes;
      int                     n;
      cprs_pkg::run_word_type outs [2];
      if (reset) begin
         axis_cfg[cprs_pkg::CSR_AXIS1_X] = cprs_pkg::AXIS_ONE;
         axis_cfg[cprs_pkg::CSR_AXIS1_Y] = cprs_pkg::AXIS_ZERO;
         axis_cfg[cprs_pkg::CSR_AXIS1_Z] = cprs_pkg::AXIS_ZERO;
         axis_cfg[cprs_pkg::CSR_AXIS2_X] = cprs_pkg::AXIS_ZERO;
         axis_cfg[cprs_pkg::CSR_AXIS2_Y] = cprs_pkg::AXIS_ONE;
         axis_cfg[cprs_pkg::CSR_AXIS2_Z] = cprs_pkg::AXIS_ZERO;
         run_par   = 1'b0;
         run_start = '0;
         ray_pos   = '0;
         run_live  = 1'b0;
      end else begin
         if (csr_valid && csr_ready && csr_index <= cprs_pkg::CSR_AXIS2_Z) begin
            axis_cfg[csr_index] = csr_data;
         end
         if (req_valid && !req_stall) begin
            rays_accepted++;
            mat = checker_bit(req_tex_u, req_tex_v, req_tex_w,
                              axis_cfg[cprs_pkg::CSR_AXIS1_X],
                              axis_cfg[cprs_pkg::CSR_AXIS1_Y],
                              axis_cfg[cprs_pkg::CSR_AXIS1_Z])
                ^ checker_bit(req_tex_u, req_tex_v, req_tex_w,
                              axis_cfg[cprs_pkg::CSR_AXIS2_X],
                              axis_cfg[cprs_pkg::CSR_AXIS2_Y],
                              axis_cfg[cprs_pkg::CSR_AXIS2_Z]);
            // a full packet ends at the last slot whatever the marker says
            closes = req_packet_end || (ray_pos >= 7'(cprs_pkg::MAX_PACKET_RAYS - 1));
            n = 0;
            if (!run_live) begin
               run_live  = 1'b1;
               run_par   = mat;
               run_start = ray_pos[5:0];
            end else if (mat != run_par) begin
               outs[n] = make_run(run_start, ray_pos, run_par);
               n++;
               run_par   = mat;
               run_start = ray_pos[5:0];
            end
            if (closes) begin
               outs[n] = make_run(run_start, ray_pos + 7'd1, run_par);
               n++;
               packets_closed++;
               run_par   = 1'b0;
               run_start = '0;
               ray_pos   = '0;
               run_live  = 1'b0;
            end else begin
               ray_pos = ray_pos + 7'd1;
            end
            if (n > 0) begin
               outs[n-1].last_result = 1'b1;
            end
            for (int i = 0; i < n; i++) begin
               pending_runs.push_back(outs[i]);
            end
         end
      end
   end

   // result checker: each accepted word against the oldest prediction
   always @(posedge clock) begin : run_check
      cprs_pkg::run_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_runs.size() == 0) begin
            error_count++;
            $display("%0t: unexpected run word begin %0d end %0d material %0d last %0d",
                     $time, rsp_run_begin, rsp_run_end, rsp_material_select,
                     rsp_last_result);
         end else begin
            want = pending_runs.pop_front();
            runs_checked++;
            if (rsp_run_begin !== want.run_begin) begin
               error_count++;
               $display("%0t: run_begin expected %0d actual %0d",
                        $time, want.run_begin, rsp_run_begin);
            end
            if (rsp_run_end !== want.run_end) begin
               error_count++;
               $display("%0t: run_end expected %0d actual %0d",
                        $time, want.run_end, rsp_run_end);
            end
            if (rsp_material_select !== want.material_select) begin
               error_count++;
               $display("%0t: material_select expected %0d actual %0d",
                        $time, want.material_select, rsp_material_select);
            end
            if (rsp_last_result !== want.last_result) begin
               error_count++;
               $display("%0t: last_result expected %0d actual %0d",
                        $time, want.last_result, rsp_last_result);
            end
         end
      end
   end

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_stall <= !calm && ($urandom_range(99) < 32);
   end

   // run limit
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t: timeout, %0d run words still outstanding", $time, pending_runs.size());
      $display("checker_parity_run_splitter_core test failed");
      $finish;
   end

   // one ray word, with a random gap in front unless the stream is calm
   task automatic send_ray(input logic [31:0] u, v, w, input logic pe);
      if (!calm && $urandom_range(99) < 32) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 2)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_tex_u      <= u;
      req_tex_v      <= v;
      req_tex_w      <= w;
      req_packet_end <= pe;
      do @(posedge clock); while (req_stall);
   endtask

   // stop sending and let every outstanding run come back
   task automatic settle_block;
      req_valid <= 1'b0;
      while (pending_runs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [cprs_pkg::CSR_IDX_W-1:0] idx,
                            input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   // load the planned axes, optionally poking the unused indexes first
   task automatic apply_axis_plan(input logic spare_too);
      settle_block();
      if (spare_too) begin
         csr_write(CSR_SPARE_LO, $urandom);
         csr_write(CSR_SPARE_HI, $urandom);
      end
      csr_write(cprs_pkg::CSR_AXIS1_X, axis_plan[cprs_pkg::CSR_AXIS1_X]);
      csr_write(cprs_pkg::CSR_AXIS1_Y, axis_plan[cprs_pkg::CSR_AXIS1_Y]);
      csr_write(cprs_pkg::CSR_AXIS1_Z, axis_plan[cprs_pkg::CSR_AXIS1_Z]);
      csr_write(cprs_pkg::CSR_AXIS2_X, axis_plan[cprs_pkg::CSR_AXIS2_X]);
      csr_write(cprs_pkg::CSR_AXIS2_Y, axis_plan[cprs_pkg::CSR_AXIS2_Y]);
      csr_write(cprs_pkg::CSR_AXIS2_Z, axis_plan[cprs_pkg::CSR_AXIS2_Z]);
      csr_valid <= 1'b0;
      settings_applied++;
   endtask

   task automatic plan_axes(input coord_kind_type kind);
      foreach (axis_plan[i]) axis_plan[i] = random_coord(kind);
   endtask

   function automatic coord_kind_type pick_kind();
      int r;
      r = $urandom_range(99);
      if (r < 50) return COORD_NEAR_INT;
      if (r < 75) return COORD_FULL;
      if (r < 85) return COORD_EXTREME;
      return COORD_ZERO;
   endfunction

   // one packet of random rays; repeats keep runs going, unmarked full packets rely on overflow
   task automatic send_random_packet(output int len);
      int          r;
      logic        marked;
      logic [31:0] u, v, w;
      r = $urandom_range(99);
      marked = 1'b1;
      if (r < 3) begin
         len = cprs_pkg::MAX_PACKET_RAYS;
         marked = 1'b0;
      end else if (r < 5) begin
         len = cprs_pkg::MAX_PACKET_RAYS;
      end else begin
         len = $urandom_range(1, 12);
      end
      u = 0;
      v = 0;
      w = 0;
      for (int i = 0; i < len; i++) begin
         if (i == 0 || $urandom_range(99) >= 40) begin
            u = random_coord(pick_kind());
            v = random_coord(pick_kind());
            w = ($urandom_range(3) == 0) ? 32'd0 : random_coord(pick_kind());
         end
         send_ray(u, v, w, (i == len - 1) && marked);
      end
   endtask

   // reset axes: fold cases, extremes, one and two runs per closing ray
   task automatic test_reset_axes;
      send_ray(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1);
      send_ray(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
      send_ray(32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 1'b1);
      send_ray(32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
      send_ray(32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
      send_ray(32'h0002_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
      send_ray(32'hFFFF_8000, 32'h0000_0000, 32'h0000_0000, 1'b0);
      send_ray(32'hFFFF_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
      send_ray(32'hFFFE_8000, 32'h0000_0000, 32'h0000_0000, 1'b0);
      send_ray(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
      send_ray(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
      send_ray(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
      send_ray(32'h8000_0001, 32'h0000_0001, 32'h8000_0000, 1'b1);
   endtask

   // extreme axes with extreme coordinates; unused indexes must leave the axes alone
   task automatic test_axis_extremes;
      foreach (axis_plan[i]) axis_plan[i] = 32'h8000_0000;
      apply_axis_plan(1'b1);
      send_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
      send_ray(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
      send_ray(32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0000, 1'b1);
      foreach (axis_plan[i]) axis_plan[i] = 32'h7FFF_FFFF;
      axis_plan[cprs_pkg::CSR_AXIS2_Y] = 32'h8000_0000;
      apply_axis_plan(1'b1);
      send_ray(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
      send_ray(32'h8000_0000, 32'hFFFF_FFFF, 32'h8000_0001, 1'b0);
      send_ray(32'h0001_0000, 32'hFFFF_0000, 32'h0000_0000, 1'b1);
   endtask

   // a packet that never marks its end closes itself at the last slot
   task automatic test_packet_overflow;
      for (int i = 0; i < cprs_pkg::MAX_PACKET_RAYS; i++) begin
         send_ray(random_coord(COORD_NEAR_INT), random_coord(COORD_NEAR_INT),
                  random_coord(COORD_FULL), 1'b0);
      end
      send_ray(32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
      send_ray(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1);
   endtask

   // random packets over a series of axis settings, the last one without idling
   task automatic test_random_phases;
      int sent;
      int len;
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               foreach (axis_plan[i]) axis_plan[i] = cprs_pkg::AXIS_ZERO;
               axis_plan[cprs_pkg::CSR_AXIS1_X] = cprs_pkg::AXIS_ONE;
               axis_plan[cprs_pkg::CSR_AXIS2_Y] = cprs_pkg::AXIS_ONE;
            end
            1: plan_axes(COORD_NEAR_INT);
            2: plan_axes(COORD_FULL);
            3: plan_axes(COORD_EXTREME);
            4: plan_axes(COORD_ZERO);
            default: plan_axes(COORD_NEAR_INT);
         endcase
         apply_axis_plan(1'b0);
         calm = (phase == 5);
         sent = 0;
         while (sent < PHASE_RAYS) begin
            send_random_packet(len);
            sent += len;
         end
      end
      settle_block();
      calm = 1'b0;
   endtask

   // sequence of tests
   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_axes();
      test_axis_extremes();
      test_packet_overflow();
      test_random_phases();
      settle_block();
      $display("covered %0d rays in %0d packets, %0d run words compared",
               rays_accepted, packets_closed, runs_checked);
      $display("axis registers loaded under %0d settings, %0d mismatches",
               settings_applied, error_count);
      if (error_count == 0) begin
         $display("checker_parity_run_splitter_core test passed");
      end else begin
         $display("checker_parity_run_splitter_core test failed");
      end
      $finish;
   end

endmodule
